// File: hdl/i2c_master_bit_engine_unit_macros.svh
// assertion macros for the i2c master bit engine checker
// expects clk_i and rst_ni in the scope of the use
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define I2C_MBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define I2C_MBE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `I2C_MBE_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `I2C_MBE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/i2c_mbe_pkg.sv
// shared types and codes for the i2c master bit engine
// no dependencies
`default_nettype none

package i2c_mbe_pkg;

  // request codes of the req_type field
  localparam logic [2:0] REQ_NONE = 3'd0;

  // sequencer state codes, a started command takes the code of its request
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_STOP  = 3'd2;
  localparam logic [2:0] ST_SEND  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_WACK  = 3'd5;
  localparam logic [2:0] ST_ACK   = 3'd6;
  localparam logic [2:0] ST_NACK  = 3'd7;

  localparam logic [2:0] BIT_LAST = 3'd7;
  localparam int unsigned MSB_POS = 7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } result_t;

  // handshake between input register and the rest
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: hdl/i2c_mbe_req_if.sv
// tick channel into the i2c master bit engine: valid/ready plus tick payload
// no dependencies
`default_nettype none

interface i2c_mbe_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output req_type, output tx_byte, output sda_in,
                  input ready);
  modport sink (input valid, input req_type, input tx_byte, input sda_in,
                output ready);
endinterface

`default_nettype wire

// File: hdl/i2c_mbe_res_if.sv
// result channel out of the i2c master bit engine: valid/ready plus line levels
// no dependencies
`default_nettype none

interface i2c_mbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_bit;

  modport source (output valid, output scl_level, output sda_level, output sda_drive,
                  output busy_res, output done_res, output rx_byte, output ack_bit,
                  input ready);
  modport sink (input valid, input scl_level, input sda_level, input sda_drive,
                input busy_res, input done_res, input rx_byte, input ack_bit,
                output ready);
endinterface

`default_nettype wire

// File: hdl/i2c_master_bit_engine_unit.sv
// I2C master bit engine, one delay tick per transfer on the req channel.
// Each tick carries the sampled SDA level and, while the engine is idle, an
// optional command (start, stop, send byte, read byte, wait ack, ack, nack).
// Every tick yields exactly one transfer on the res channel with the SCL/SDA
// levels, the SDA output enable, busy/done flags, the last read byte and the
// last sampled acknowledge. Commands that arrive while busy are dropped.
// A taken tick passes the input register, then the result register, from
// which its result leaves on the res channel.
// Throughput: one tick per clock while res ready is high, limited by the
// single-step sequencer update between the two registers.
// Reset: the engine goes idle with SCL and SDA high and SDA driven; both
// channels are empty and req ready is high.
// Stall: when res ready is low the result register holds, one more tick
// waits in the input register, then req ready drops until res moves again.
// Depends on i2c_mbe_pkg, i2c_mbe_req_if, i2c_mbe_res_if and the submodules.
`default_nettype none

module i2c_master_bit_engine_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  i2c_mbe_req_if.sink   req_i,
  i2c_mbe_res_if.source res_o
);
  import i2c_mbe_pkg::*;

  tick_t      in_tick;
  tick_t      stage_tick;
  stage_ctl_t stage_ctl;
  result_t    step_res;
  result_t    out_res;
  logic       out_free;
  logic       in_ready;
  logic       out_valid;

  assign in_tick.req_type = req_i.req_type;
  assign in_tick.tx_byte  = req_i.tx_byte;
  assign in_tick.sda_in   = req_i.sda_in;
  assign req_i.ready      = in_ready;

  i2c_mbe_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .in_tick_i  (in_tick),
    .out_free_i (out_free),
    .ctl_o      (stage_ctl),
    .tick_o     (stage_tick)
  );

  i2c_mbe_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (stage_ctl.advance),
    .tick_i    (stage_tick),
    .result_o  (step_res)
  );

  i2c_mbe_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_ctl.valid & stage_ctl.advance),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .result_o    (out_res)
  );

  assign res_o.valid     = out_valid;
  assign res_o.scl_level = out_res.scl_level;
  assign res_o.sda_level = out_res.sda_level;
  assign res_o.sda_drive = out_res.sda_drive;
  assign res_o.busy_res  = out_res.busy_res;
  assign res_o.done_res  = out_res.done_res;
  assign res_o.rx_byte   = out_res.rx_byte;
  assign res_o.ack_bit   = out_res.ack_bit;

endmodule

`default_nettype wire

// File: hdl/i2c_mbe_in_stage.sv
// input register of the i2c master bit engine
// depends on i2c_mbe_pkg
`default_nettype none

module i2c_mbe_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire i2c_mbe_pkg::tick_t  in_tick_i,
  input  wire logic                out_free_i,
  output i2c_mbe_pkg::stage_ctl_t ctl_o,
  output i2c_mbe_pkg::tick_t       tick_o
);
  import i2c_mbe_pkg::*;

  logic  valid_q, valid_d;
  tick_t tick_q;
  logic  advance;
  logic  take;

  assign advance    = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | advance;
  assign take       = in_valid_i & in_ready_o;
  assign valid_d    = take | (valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tick_q <= in_tick_i;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.advance = advance;
  assign tick_o        = tick_q;

endmodule

`default_nettype wire

// File: hdl/i2c_mbe_seq.sv
// command sequencer: line level state and one step per tick
// depends on i2c_mbe_pkg
`default_nettype none

module i2c_mbe_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_en_i,
  input  wire i2c_mbe_pkg::tick_t  tick_i,
  output i2c_mbe_pkg::result_t     result_o
);
  import i2c_mbe_pkg::*;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       oe_q, oe_d;
  logic [7:0] rx_q, rx_d;
  logic       fin;
  logic       wrap;
  logic       active;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    oe_d    = oe_q;
    rx_d    = rx_q;
    fin     = 1'b0;
    wrap    = 1'b0;
    active  = 1'b0;

    // a request only starts when idle, its first step runs on the same tick
    if (state_q == ST_IDLE && tick_i.req_type != REQ_NONE) begin
      state_d = tick_i.req_type;
      phase_d = 2'd0;
      bit_d   = 3'd0;
      if (tick_i.req_type == ST_SEND) begin
        shift_d = tick_i.tx_byte;
      end else if (tick_i.req_type == ST_READ) begin
        shift_d = 8'd0;
      end
    end

    if (state_d != ST_IDLE) begin
      active = 1'b1;
      unique case (state_d)
        ST_START: begin
          unique case (phase_d)
            2'd0: begin oe_d = 1'b1; sda_d = 1'b1; end
            2'd1: scl_d = 1'b1;
            2'd2: sda_d = 1'b0;
            default: begin scl_d = 1'b0; fin = 1'b1; end
          endcase
        end
        ST_STOP: begin
          unique case (phase_d)
            2'd0: begin oe_d = 1'b1; sda_d = 1'b0; end
            2'd1: scl_d = 1'b1;
            default: begin sda_d = 1'b1; fin = 1'b1; end
          endcase
        end
        ST_SEND: begin
          unique case (phase_d)
            2'd0: begin oe_d = 1'b1; sda_d = shift_d[MSB_POS]; end
            2'd1: scl_d = 1'b1;
            default: begin
              scl_d   = 1'b0;
              shift_d = {shift_d[6:0], 1'b0};
              if (bit_d == BIT_LAST) begin
                sda_d = 1'b1;
                fin   = 1'b1;
              end else begin
                bit_d = bit_d + 3'd1;
                wrap  = 1'b1;
              end
            end
          endcase
        end
        ST_READ: begin
          if (phase_d == 2'd0) begin
            // release sda together with the first clock high
            if (bit_d == 3'd0) begin
              sda_d = 1'b1;
              oe_d  = 1'b0;
            end
            scl_d = 1'b1;
          end else begin
            shift_d = {shift_d[6:0], tick_i.sda_in};
            scl_d   = 1'b0;
            if (bit_d == BIT_LAST) begin
              rx_d = shift_d;
              fin  = 1'b1;
            end else begin
              bit_d = bit_d + 3'd1;
              wrap  = 1'b1;
            end
          end
        end
        ST_WACK: begin
          unique case (phase_d)
            2'd0: begin sda_d = 1'b1; oe_d = 1'b0; end
            2'd1: scl_d = 1'b1;
            default: begin ack_d = tick_i.sda_in; scl_d = 1'b0; fin = 1'b1; end
          endcase
        end
        ST_ACK: begin
          unique case (phase_d)
            2'd0: begin oe_d = 1'b1; sda_d = 1'b0; end
            2'd1: scl_d = 1'b1;
            2'd2: scl_d = 1'b0;
            default: begin sda_d = 1'b1; fin = 1'b1; end
          endcase
        end
        ST_NACK: begin
          unique case (phase_d)
            2'd0: begin oe_d = 1'b1; sda_d = 1'b1; end
            2'd1: scl_d = 1'b1;
            default: begin scl_d = 1'b0; fin = 1'b1; end
          endcase
        end
        default: fin = 1'b1;
      endcase

      if (fin) begin
        state_d = ST_IDLE;
        phase_d = 2'd0;
        bit_d   = 3'd0;
      end else if (wrap) begin
        phase_d = 2'd0;
      end else begin
        phase_d = phase_d + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b1;
      rx_q    <= 8'd0;
    end else if (step_en_i) begin
      state_q <= state_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      rx_q    <= rx_d;
    end
  end

  assign result_o.scl_level = scl_d;
  assign result_o.sda_level = sda_d;
  assign result_o.sda_drive = oe_d;
  assign result_o.busy_res  = (state_d != ST_IDLE);
  assign result_o.done_res  = active & fin;
  assign result_o.rx_byte   = rx_d;
  assign result_o.ack_bit   = ack_d;

endmodule

`default_nettype wire

// File: hdl/i2c_mbe_out_stage.sv
// result register of the i2c master bit engine
// depends on i2c_mbe_pkg
`default_nettype none

module i2c_mbe_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire i2c_mbe_pkg::result_t  result_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output i2c_mbe_pkg::result_t       result_o
);
  import i2c_mbe_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // free when empty or the held result leaves this cycle
  assign free_o  = ~valid_q | out_ready_i;
  assign valid_d = load_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// File: hdl/i2c_mbe_checker.sv
// port-level checks for the i2c master bit engine, bound to the top level
// depends on i2c_master_bit_engine_unit_macros.svh and the top level ports
`default_nettype none

`include "i2c_master_bit_engine_unit_macros.svh"

module i2c_mbe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       req_ready_i,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic       scl_level_i,
  input wire logic       sda_level_i,
  input wire logic       sda_drive_i,
  input wire logic       busy_res_i,
  input wire logic       done_res_i,
  input wire logic [7:0] rx_byte_i,
  input wire logic       ack_bit_i
);

  logic [13:0] res_word;
  assign res_word = {scl_level_i, sda_level_i, sda_drive_i, busy_res_i, done_res_i,
                     rx_byte_i, ack_bit_i};

  `I2C_MBE_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_word), "stalled result changed")
  `I2C_MBE_ASSERT_IMPLY(a_done_idle, res_valid_i && done_res_i, !busy_res_i, "done while still busy")
  `I2C_MBE_ASSERT_IMPLY(a_release_high, res_valid_i && !sda_drive_i, sda_level_i, "sda released but level low")
  `I2C_MBE_ASSERT_IMPLY(a_ready_stall, !req_ready_i, res_valid_i && !res_ready_i, "req blocked without output stall")

endmodule

bind i2c_master_bit_engine_unit i2c_mbe_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .scl_level_i (res_o.scl_level),
  .sda_level_i (res_o.sda_level),
  .sda_drive_i (res_o.sda_drive),
  .busy_res_i  (res_o.busy_res),
  .done_res_i  (res_o.done_res),
  .rx_byte_i   (res_o.rx_byte),
  .ack_bit_i   (res_o.ack_bit)
);

`default_nettype wire
